// ===== hw/rtl/lrukv_pkg.sv =====
package lrukv_pkg;

   localparam int SLOTS = 16;                                   // 2 .. 64
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int KEY_W = 32;
   localparam int DATA_W = 32;
   localparam int CAP_W = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic {
      KIND_GET = 1'b0,
      KIND_PUT = 1'b1
   } kind_type;

   typedef struct packed {
      logic             present;
      logic [IDX_W-1:0] found;
      logic [IDX_W-1:0] lru;
      logic [IDX_W-1:0] free;
   } lrukv_sel_type;

endpackage

// ===== hw/rtl/lru_key_value_store_core.sv =====
// Fully associative key-value store with least-recently-used replacement.
// req channel: one word per operation (kind 0 get, kind 1 put) with key and
// value. rsp channel: one word per request, in order, with hit, read value,
// evicted flag and evicted key. csr channel: writes the capacity register
// (0 acts as 1, values above the slot count act as the slot count); write
// it only while no request is in flight.
// A request word lands in an input register; the edge that moves it on does the
// full key compare over all slots, the recency rank update and the slot write,
// and loads the result register that drives rsp_valid. Throughput is one
// request per cycle while rsp is not stalled, bounded by the combinational
// compare and rank update.
// rsp stalls back up one stage: the input register holds its word while the
// result register is full and not taken, and req_ready drops only when both
// are occupied.
// Synchronous reset empties the store and sets capacity to 16; no clearing
// pass is needed.
module lru_key_value_store_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_kind,
   input  logic signed [lrukv_pkg::KEY_W-1:0]  req_lookup_key,
   input  logic signed [lrukv_pkg::DATA_W-1:0] req_store_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_hit,
   output logic signed [lrukv_pkg::DATA_W-1:0] rsp_read_value,
   output logic                                rsp_evicted,
   output logic signed [lrukv_pkg::KEY_W-1:0]  rsp_evicted_key,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lrukv_pkg::CAP_W-1:0]         csr_capacity
);
   import lrukv_pkg::*;

   logic [CAP_W-1:0]  cap_ff;
   logic              in_vld_ff;
   kind_type          in_kind_ff;
   logic [KEY_W-1:0]  in_key_ff;
   logic [DATA_W-1:0] in_val_ff;
   logic              out_vld_ff;
   logic              out_hit_ff;
   logic [DATA_W-1:0] out_rd_ff;
   logic              out_ev_ff;
   logic [KEY_W-1:0]  out_evk_ff;

   logic [KEY_W-1:0]  key_ff [SLOTS];
   logic [DATA_W-1:0] data_ff [SLOTS];
   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic [IDX_W-1:0]  rec_ff [SLOTS];
   logic [IDX_W-1:0]  rec_in [SLOTS];
   logic [CNT_W-1:0]  used_ff, used_in;

   lrukv_sel_type     sel;
   logic              advance;
   logic              fire;
   logic              is_put;
   logic [CNT_W-1:0]  eff_cap;
   logic              full;
   logic              touch;
   logic              age_all;
   logic [IDX_W-1:0]  tgt;
   logic [IDX_W-1:0]  thr;

   assign advance   = !out_vld_ff || rsp_ready;
   assign fire      = in_vld_ff && advance;
   assign req_ready = !in_vld_ff || advance;
   assign csr_ready = 1'b1;
   assign is_put    = (in_kind_ff == KIND_PUT);

   lrukv_lookup u_lookup (
      .slot_key   (key_ff),
      .slot_valid (valid_ff),
      .slot_rec   (rec_ff),
      .used_count (used_ff),
      .key        (in_key_ff),
      .sel        (sel)
   );

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if (32'(cap_ff) > SLOTS) begin
         eff_cap = CNT_W'(SLOTS);
      end else begin
         eff_cap = CNT_W'(cap_ff);
      end
   end

   assign full = (used_ff >= eff_cap);

   always_comb begin
      valid_in = valid_ff;
      used_in  = used_ff;
      rec_in   = rec_ff;
      touch    = 1'b0;
      age_all  = 1'b0;
      tgt      = sel.found;
      if (fire) begin
         if (sel.present) begin
            touch = 1'b1;
         end else if (is_put) begin
            touch = 1'b1;
            if (full) begin
               tgt = sel.lru;
            end else begin
               tgt           = sel.free;
               age_all       = 1'b1;
               valid_in[tgt] = 1'b1;
               used_in       = used_ff + CNT_W'(1);
            end
         end
      end
      thr = rec_ff[tgt];
      if (touch) begin
         // entries more recent than the touched one age by one; an insert into a free slot ages every valid entry
         for (int i = 0; i < SLOTS; i++) begin
            if (valid_ff[i] && (IDX_W'(i) != tgt) && (age_all || rec_ff[i] < thr)) begin
               rec_in[i] = rec_ff[i] + IDX_W'(1);
            end
         end
         rec_in[tgt] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff     <= CAP_RESET;
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         valid_ff   <= '0;
         used_ff    <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            rec_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_capacity;
         end
         if (req_valid && req_ready) begin
            in_vld_ff <= 1'b1;
         end else if (fire) begin
            in_vld_ff <= 1'b0;
         end
         if (fire) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
         valid_ff <= valid_in;
         used_ff  <= used_in;
         rec_ff   <= rec_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_kind_ff <= kind_type'(req_kind);
         in_key_ff  <= $unsigned(req_lookup_key);
         in_val_ff  <= $unsigned(req_store_value);
      end
      if (fire) begin
         out_hit_ff <= sel.present;
         out_rd_ff  <= (sel.present && !is_put) ? data_ff[sel.found] : '0;
         out_ev_ff  <= !sel.present && is_put && full;
         out_evk_ff <= (!sel.present && is_put && full) ? key_ff[sel.lru] : '0;
         if (is_put) begin
            data_ff[tgt] <= in_val_ff;
            if (!sel.present) begin
               key_ff[tgt] <= in_key_ff;
            end
         end
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_hit         = out_hit_ff;
   assign rsp_read_value  = $signed(out_rd_ff);
   assign rsp_evicted     = out_ev_ff;
   assign rsp_evicted_key = $signed(out_evk_ff);

endmodule

// ===== hw/rtl/lrukv_lookup.sv =====
module lrukv_lookup (
   input  logic [lrukv_pkg::KEY_W-1:0] slot_key  [lrukv_pkg::SLOTS],
   input  logic [lrukv_pkg::SLOTS-1:0] slot_valid,
   input  logic [lrukv_pkg::IDX_W-1:0] slot_rec  [lrukv_pkg::SLOTS],
   input  logic [lrukv_pkg::CNT_W-1:0] used_count,
   input  logic [lrukv_pkg::KEY_W-1:0] key,
   output lrukv_pkg::lrukv_sel_type    sel
);
   import lrukv_pkg::*;

   logic [SLOTS-1:0] match;
   logic [SLOTS-1:0] oldest;
   logic [CNT_W-1:0] last_rank;

   // valid ranks are unique, so the oldest entry is the one ranked used_count-1
   assign last_rank = used_count - CNT_W'(1);

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match[i]  = slot_valid[i] && (slot_key[i] == key);
         oldest[i] = slot_valid[i] && (CNT_W'(slot_rec[i]) == last_rank);
      end
   end

   // lowest index wins in every search
   always_comb begin
      sel.present = |match;
      sel.found   = '0;
      sel.lru     = '0;
      sel.free    = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (match[i]) begin
            sel.found = IDX_W'(i);
         end
         if (oldest[i]) begin
            sel.lru = IDX_W'(i);
         end
         if (!slot_valid[i]) begin
            sel.free = IDX_W'(i);
         end
      end
   end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import lrukv_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 10;
   localparam int PHASE_COUNT = 9;
   localparam int PHASE_ITEMS = 90;

   typedef struct {
      logic              hit;
      logic [DATA_W-1:0] read_value;
      logic              evicted;
      logic [KEY_W-1:0]  evicted_key;
   } kv_rsp_type;

   // Keeps its own copy of the store and checks rsp words against it in order.
   class lru_tracker;
      logic [KEY_W-1:0]  key_tab[SLOTS];
      logic [DATA_W-1:0] data_tab[SLOTS];
      bit                live[SLOTS];
      int                rank[SLOTS];
      int                used;
      int                capacity;
      int                mismatches;
      kv_rsp_type        pending_rsp[$];

      function new();
         used = 0;
         capacity = int'(CAP_RESET);
         mismatches = 0;
         foreach (live[i]) begin
            live[i] = 1'b0;
            rank[i] = 0;
         end
      endfunction

      function void set_capacity(logic [CAP_W-1:0] cap);
         capacity = int'(cap);
      endfunction

      // slot s becomes most recent; newer live slots age by one
      function void promote(int s);
         int r;
         r = rank[s];
         foreach (live[i]) begin
            if (live[i] && i != s && rank[i] < r)
               rank[i]++;
         end
         rank[s] = 0;
      endfunction

      function kv_rsp_type predict_access(kind_type kind, logic [KEY_W-1:0] key,
                                          logic [DATA_W-1:0] value);
         kv_rsp_type r;
         int found;
         int target;
         int oldest;
         int limit;
         r.hit = 1'b0;
         r.read_value = '0;
         r.evicted = 1'b0;
         r.evicted_key = '0;
         found = -1;
         for (int i = 0; i < SLOTS; i++) begin
            if (live[i] && key_tab[i] == key) begin
               found = i;
               break;
            end
         end
         if (found >= 0) begin
            r.hit = 1'b1;
            if (kind == KIND_GET)
               r.read_value = data_tab[found];
            else
               data_tab[found] = value;
            promote(found);
         end else if (kind == KIND_PUT) begin
            limit = capacity;
            if (limit < 1)
               limit = 1;
            if (limit > SLOTS)
               limit = SLOTS;
            if (used >= limit) begin
               // count never shrinks, so a full store replaces its oldest entry
               target = 0;
               oldest = -1;
               for (int i = 0; i < SLOTS; i++) begin
                  if (live[i] && rank[i] > oldest) begin
                     oldest = rank[i];
                     target = i;
                  end
               end
               r.evicted = 1'b1;
               r.evicted_key = key_tab[target];
               key_tab[target] = key;
               data_tab[target] = value;
               promote(target);
            end else begin
               target = 0;
               for (int i = 0; i < SLOTS; i++) begin
                  if (!live[i]) begin
                     target = i;
                     break;
                  end
               end
               foreach (live[i]) begin
                  if (live[i])
                     rank[i]++;
               end
               live[target] = 1'b1;
               key_tab[target] = key;
               data_tab[target] = value;
               rank[target] = 0;
               used++;
            end
         end
         return r;
      endfunction

      function void note_request(kind_type kind, logic [KEY_W-1:0] key,
                                 logic [DATA_W-1:0] value);
         pending_rsp.push_back(predict_access(kind, key, value));
      endfunction

      function void check_response(logic hit, logic [DATA_W-1:0] read_value,
                                   logic evicted, logic [KEY_W-1:0] evicted_key);
         kv_rsp_type exp;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected rsp word: hit=%0b rd=%h ev=%0b evk=%h",
                        hit, read_value, evicted, evicted_key);
            return;
         end
         exp = pending_rsp.pop_front();
         if (exp.hit !== hit || exp.read_value !== read_value ||
             exp.evicted !== evicted || exp.evicted_key !== evicted_key) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $write("rsp mismatch: exp hit=%0b rd=%h ev=%0b evk=%h, ",
                      exp.hit, exp.read_value, exp.evicted, exp.evicted_key);
               $display("got hit=%0b rd=%h ev=%0b evk=%h",
                        hit, read_value, evicted, evicted_key);
            end
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_kind = KIND_GET;
   logic signed [KEY_W-1:0]  req_lookup_key = '0;
   logic signed [DATA_W-1:0] req_store_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_hit;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic                     rsp_evicted;
   logic signed [KEY_W-1:0]  rsp_evicted_key;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CAP_W-1:0]         csr_capacity = '0;

   lru_tracker tracker;
   bit         idle_en = 1'b1;
   int         stall_left = 0;
   int         cycle_count = 0;

   lru_key_value_store_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_lookup_key  (req_lookup_key),
      .req_store_value (req_store_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_capacity    (csr_capacity)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // rsp stalls in random bursts, started only while idle_en is set
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_response(rsp_hit, rsp_read_value, rsp_evicted, rsp_evicted_key);
   end

   // valid stays high after acceptance; the caller decides whether the next word follows
   task automatic send_item(input kind_type kind, input logic [KEY_W-1:0] key,
                            input logic [DATA_W-1:0] value);
      req_valid <= 1'b1;
      req_kind <= kind;
      req_lookup_key <= key;
      req_store_value <= value;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(kind, key, value);
   endtask

   task automatic idle_req(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_store();
      req_valid <= 1'b0;
      while (tracker.pending_rsp.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      drain_store();
      csr_valid <= 1'b1;
      csr_capacity <= cap;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tracker.set_capacity(cap);
   endtask

   task automatic run_phase(input int count, input int pool_n);
      logic [KEY_W-1:0] pool[32];
      logic [KEY_W-1:0] key;
      kind_type         kind;
      for (int i = 0; i < pool_n; i++)
         pool[i] = $urandom;
      for (int i = 0; i < count; i++) begin
         if (idle_en && $urandom_range(0, 3) == 0)
            idle_req($urandom_range(1, 3));
         if ($urandom_range(0, 9) == 0)
            key = $urandom;
         else
            key = pool[$urandom_range(0, pool_n - 1)];
         kind = kind_type'($urandom_range(0, 1));
         send_item(kind, key, $urandom);
      end
   endtask

   task automatic run_directed();
      // zero capacity acts as one entry
      write_capacity(CAP_W'(0));
      send_item(KIND_GET, 32'h0000_0000, 32'h0000_0000);
      send_item(KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(KIND_GET, 32'h8000_0000, 32'hFFFF_FFFF);
      send_item(KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(KIND_GET, 32'h8000_0000, 32'h0000_0000);
      send_item(KIND_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_item(KIND_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      send_item(KIND_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(KIND_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_item(KIND_GET, 32'h0000_0000, 32'h8000_0000);
      send_item(KIND_GET, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
   endtask

   initial begin
      int caps[PHASE_COUNT];
      int pools[PHASE_COUNT];
      tracker = new();
      // capacity rises so the entry count grows, then drops below the count
      caps = '{1, 4, 8, 31, 17, 3, 16, 0, 16};
      pools = '{4, 8, 12, 24, 20, 6, 20, 0, 24};
      caps[7] = $urandom_range(0, 31);
      pools[7] = $urandom_range(2, 24);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int p = 0; p < PHASE_COUNT; p++) begin
         idle_en <= (p != 6 && p != PHASE_COUNT - 1);
         write_capacity(CAP_W'(caps[p]));
         if (p == 3) begin
            // sender holds off mid-phase until the store has answered everything
            run_phase(PHASE_ITEMS / 2, pools[p]);
            drain_store();
            run_phase(PHASE_ITEMS / 2, pools[p]);
         end else begin
            run_phase(PHASE_ITEMS, pools[p]);
         end
      end
      drain_store();
      repeat (10) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending_rsp.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
